/* hdl/tsr_pkg.sv */
package tsr_pkg;

	// user-facing defaults
	localparam int unsigned TERMS_DEF         = 10;
	localparam int unsigned OUT_FRAC_BITS_DEF = 30;

	// port field widths
	localparam int unsigned ANGLE_W = 32;
	localparam int unsigned SINE_W  = 32;

	// internal fixed point is q.56
	localparam int unsigned WFRAC = 56;

	localparam int unsigned MAG_W   = 32;  // |angle|, up to 2^31
	localparam int unsigned RECIP_W = 30;
	localparam int unsigned Q_W     = 5;   // whole turns, at most 20
	localparam int unsigned XW_W    = 64;  // |angle| in q.56
	localparam int unsigned RED_W   = 59;  // remainder below 2*pi
	localparam int unsigned R_W     = 58;  // folded remainder, at most pi
	localparam int unsigned X2_W    = 60;  // r^2 below 16
	localparam int unsigned TERM_W  = 59;  // series term below 8
	localparam int unsigned N_W     = 63;  // term * r^2 before the divide
	localparam int unsigned REC_W   = 64;  // reciprocal of a term divisor
	localparam int unsigned SUM_W   = 61;  // signed partial sum
	localparam int unsigned LO_W    = 32;  // low slice of a split product

	localparam logic [RECIP_W-1:0] RECIP_2PI = 30'h28BE60DC;           // 1/(2*pi), q0.32
	localparam logic [RED_W-1:0]   TWO_PI    = 59'h6487ED5110B4612;    // q.56
	localparam logic [R_W-1:0]     PI        = 58'h3243F6A8885A309;    // q.56

	typedef struct packed {
		logic valid;
		logic neg;
	} ctl_t;

endpackage

/* hdl/tsr_ifs.sv */
interface tsr_angle_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsr_pkg::ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

interface tsr_sine_if;
	logic                               valid;
	logic                               ready;
	logic signed [tsr_pkg::SINE_W-1:0] sine;

	modport source (output valid, output sine, input ready);
	modport sink (input valid, input sine, output ready);
endinterface

/* hdl/tsr_mul.sv */
module tsr_mul #(
	parameter int unsigned A_W   = tsr_pkg::TERM_W,
	parameter int unsigned B_W   = tsr_pkg::X2_W,
	parameter int unsigned SHIFT = tsr_pkg::WFRAC,
	parameter int unsigned P_W   = tsr_pkg::N_W
) (
	input  logic           clk,
	input  logic           en,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic [P_W-1:0] p
);

	localparam int unsigned LoW = tsr_pkg::LO_W;
	localparam int unsigned AhW = A_W - LoW;
	localparam int unsigned BhW = B_W - LoW;
	localparam int unsigned FW  = A_W + B_W;

	logic [2*LoW-1:0]   ll_s1;
	logic [LoW+BhW-1:0] lh_s1;
	logic [AhW+LoW-1:0] hl_s1;
	logic [AhW+BhW-1:0] hh_s1;
	logic [FW-1:0]      full;
	logic [P_W-1:0]     p_s2;

	// four partial products, each at most 32x32
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= (2*LoW)'(a[LoW-1:0]) * (2*LoW)'(b[LoW-1:0]);
			lh_s1 <= (LoW+BhW)'(a[LoW-1:0]) * (LoW+BhW)'(b[B_W-1:LoW]);
			hl_s1 <= (AhW+LoW)'(a[A_W-1:LoW]) * (AhW+LoW)'(b[LoW-1:0]);
			hh_s1 <= (AhW+BhW)'(a[A_W-1:LoW]) * (AhW+BhW)'(b[B_W-1:LoW]);
		end
	end

	assign full = (FW'(hh_s1) << (2*LoW)) + (FW'(lh_s1) << LoW)
		+ (FW'(hl_s1) << LoW) + FW'(ll_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= P_W'(full >> SHIFT);
		end
	end

	assign p = p_s2;

endmodule

/* hdl/tsr_reduce.sv */
module tsr_reduce (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  logic signed [tsr_pkg::ANGLE_W-1:0] angle,
	output tsr_pkg::ctl_t                       ctl_fwd,
	output logic [tsr_pkg::TERM_W-1:0]          term_fwd,
	output logic [tsr_pkg::X2_W-1:0]            x2_fwd,
	output logic signed [tsr_pkg::SUM_W-1:0]    sum_fwd
);

	localparam int unsigned MagW   = tsr_pkg::MAG_W;
	localparam int unsigned ProdW  = tsr_pkg::MAG_W + tsr_pkg::RECIP_W;
	localparam int unsigned QW     = tsr_pkg::Q_W;
	localparam int unsigned XwW    = tsr_pkg::XW_W;
	localparam int unsigned RedW   = tsr_pkg::RED_W;
	localparam int unsigned RW     = tsr_pkg::R_W;
	localparam int unsigned X2W    = tsr_pkg::X2_W;
	localparam int unsigned TermW  = tsr_pkg::TERM_W;
	localparam int unsigned SumW   = tsr_pkg::SUM_W;
	localparam int unsigned AngleW = tsr_pkg::ANGLE_W;

	logic [AngleW-1:0] raw;
	logic [ProdW-1:0]  q_prod;
	logic [XwW-1:0]    xw;
	logic              fold;

	tsr_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;

	logic [MagW-1:0] mag_s1, mag_s2, mag_s3;
	logic [QW-1:0]   q_s2;
	logic [XwW-1:0]  qt_s3;
	logic [XwW-1:0]  diff_s4;
	logic            brw_s4;
	logic [XwW-1:0]  ra_s5;
	logic [RedW-1:0] rb_s6;
	logic [RW-1:0]   r_s7, r_s8, r_s9;
	logic [X2W-1:0]  x2;

	assign raw    = angle;
	assign q_prod = ProdW'(mag_s1) * ProdW'(tsr_pkg::RECIP_2PI);
	assign xw     = {mag_s3, {(XwW-MagW){1'b0}}};
	assign fold   = rb_s6 > RedW'(tsr_pkg::PI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: valid, neg: raw[AngleW-1]};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= '{valid: ctl_s6.valid, neg: ctl_s6.neg ^ fold};
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// most negative angle negates onto itself, which is its magnitude
			mag_s1  <= raw[AngleW-1] ? MagW'(0 - raw) : MagW'(raw);
			// truncated turn count from the constant reciprocal
			q_s2    <= q_prod[tsr_pkg::WFRAC +: QW];
			mag_s2  <= mag_s1;
			qt_s3   <= XwW'(q_s2) * XwW'(tsr_pkg::TWO_PI);
			mag_s3  <= mag_s2;
			diff_s4 <= xw - qt_s3;
			brw_s4  <= qt_s3 > xw;
			// turn count one too high: give one turn back
			ra_s5   <= brw_s4 ? diff_s4 + XwW'(tsr_pkg::TWO_PI) : diff_s4;
			// one too low: take one more turn off
			rb_s6   <= RedW'((ra_s5 >= XwW'(tsr_pkg::TWO_PI)) ?
				ra_s5 - XwW'(tsr_pkg::TWO_PI) : ra_s5);
			// fold past pi, sign flipped in the control path
			r_s7    <= fold ? RW'(rb_s6 - RedW'(tsr_pkg::PI)) : RW'(rb_s6);
			r_s8    <= r_s7;
			r_s9    <= r_s8;
		end
	end

	tsr_mul #(
		.A_W   (RW),
		.B_W   (RW),
		.SHIFT (tsr_pkg::WFRAC),
		.P_W   (X2W)
	) u_sq (
		.clk (clk),
		.en  (en),
		.a   (r_s7),
		.b   (r_s7),
		.p   (x2)
	);

	assign ctl_fwd  = ctl_s9;
	assign term_fwd = TermW'(r_s9);
	assign x2_fwd   = x2;
	assign sum_fwd  = $signed(SumW'(r_s9));

endmodule

/* hdl/tsr_cell.sv */
module tsr_cell #(
	parameter int unsigned K = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  tsr_pkg::ctl_t                    ctl,
	input  logic [tsr_pkg::TERM_W-1:0]       term,
	input  logic [tsr_pkg::X2_W-1:0]         x2,
	input  logic signed [tsr_pkg::SUM_W-1:0] sum,
	output tsr_pkg::ctl_t                    ctl_fwd,
	output logic [tsr_pkg::TERM_W-1:0]       term_fwd,
	output logic [tsr_pkg::X2_W-1:0]         x2_fwd,
	output logic signed [tsr_pkg::SUM_W-1:0] sum_fwd
);

	localparam int unsigned TermW    = tsr_pkg::TERM_W;
	localparam int unsigned X2W      = tsr_pkg::X2_W;
	localparam int unsigned SumW     = tsr_pkg::SUM_W;
	localparam int unsigned NW       = tsr_pkg::N_W;
	localparam int unsigned RecW     = tsr_pkg::REC_W;
	localparam int unsigned Div      = (2 * K) * (2 * K + 1);
	localparam int unsigned RecShift = NW + $clog2(Div);
	localparam logic [127:0] RecPow  = 128'd1 << RecShift;
	// rounded-up reciprocal, exact floor for any n below 2^NW
	localparam logic [RecW-1:0] RecM = RecW'((RecPow + 128'(Div) - 128'd1) / 128'(Div));
	localparam bit Subtract          = (K % 2) == 1;

	logic [NW-1:0]    n;
	logic [TermW-1:0] term_new;
	logic signed [SumW-1:0] term_ext;

	tsr_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [X2W-1:0]         x2_s1, x2_s2, x2_s3, x2_s4, x2_s5;
	logic signed [SumW-1:0] sum_s1, sum_s2, sum_s3, sum_s4, sum_s5;
	logic [TermW-1:0]       term_s5;

	// term * r^2, back to q.56
	tsr_mul #(
		.A_W   (TermW),
		.B_W   (X2W),
		.SHIFT (tsr_pkg::WFRAC),
		.P_W   (NW)
	) u_pow (
		.clk (clk),
		.en  (en),
		.a   (term),
		.b   (x2),
		.p   (n)
	);

	// divide by (2k)(2k+1)
	tsr_mul #(
		.A_W   (NW),
		.B_W   (RecW),
		.SHIFT (RecShift),
		.P_W   (TermW)
	) u_div (
		.clk (clk),
		.en  (en),
		.a   (n),
		.b   (RecM),
		.p   (term_new)
	);

	assign term_ext = $signed(SumW'(term_new));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1   <= x2;
			x2_s2   <= x2_s1;
			x2_s3   <= x2_s2;
			x2_s4   <= x2_s3;
			x2_s5   <= x2_s4;
			sum_s1  <= sum;
			sum_s2  <= sum_s1;
			sum_s3  <= sum_s2;
			sum_s4  <= sum_s3;
			// odd cells subtract, even cells add
			sum_s5  <= Subtract ? sum_s4 - term_ext : sum_s4 + term_ext;
			term_s5 <= term_new;
		end
	end

	assign ctl_fwd  = ctl_s5;
	assign term_fwd = term_s5;
	assign x2_fwd   = x2_s5;
	assign sum_fwd  = sum_s5;

endmodule

/* hdl/taylor_sine_range_reduced.sv */
// Sine of a fixed-point angle. Each angle beat carries a signed Q8.24 angle in radians; each
// sine beat returns its sine as signed Q2.OUT_FRAC_BITS (Q2.30 by default), rounded half away
// from zero and clamped to +-1.0, one result per angle and in order. Internally the magnitude
// of the angle is brought into [0, 2*pi) with a turn count from a constant reciprocal,
// corrected by one turn either way, folded into [0, pi] with a sign flip, and then fed through
// a row of TERMS-1 term cells that each build the next odd Taylor term from the previous one
// and subtract it from or add it to a running sum in turn, all in q.56. sin(-x) comes out as
// exactly -sin(x). The block accepts one angle per clock and keeps that pace for as long as
// sine beats are taken. An accepted angle passes through the reduction and squaring
// registers, the registers of each term cell (two split multiplies of two stages each, then
// the sum update), the rounding and sign registers, and the output queue. A two-entry output
// queue lets the pipeline keep taking angles while a finished sine waits; when it fills, the
// whole pipeline holds.
module taylor_sine_range_reduced #(
	parameter int unsigned TERMS         = tsr_pkg::TERMS_DEF,
	parameter int unsigned OUT_FRAC_BITS = tsr_pkg::OUT_FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tsr_angle_if.sink  angle_chan,
	tsr_sine_if.source sine_chan
);

	localparam int unsigned TermW = tsr_pkg::TERM_W;
	localparam int unsigned X2W   = tsr_pkg::X2_W;
	localparam int unsigned SumW  = tsr_pkg::SUM_W;
	localparam int unsigned SineW = tsr_pkg::SINE_W;
	// rounding works on the magnitude, one bit wider for the carry
	localparam int unsigned RndW  = SumW + 1;
	localparam int unsigned Sh    = tsr_pkg::WFRAC - OUT_FRAC_BITS;
	localparam int unsigned ResW  = OUT_FRAC_BITS + 1;
	localparam logic [RndW-1:0] Half = RndW'(1) << (Sh - 1);
	localparam logic [RndW-1:0] One  = RndW'(1) << OUT_FRAC_BITS;
	localparam logic [1:0] QDepth    = 2'd2;

	// pipeline advance: everything moves unless the output queue is full
	logic adv;
	logic push;
	logic pop;

	// links of the cell row: index 0 from the reducer, index k out of cell k
	tsr_pkg::ctl_t          ctl_c  [TERMS];
	logic [TermW-1:0]       term_c [TERMS];
	logic [X2W-1:0]         x2_c   [TERMS];
	logic signed [SumW-1:0] sum_c  [TERMS];

	// output stages
	tsr_pkg::ctl_t          ctl_s1, ctl_s2, ctl_s3;
	logic [SumW-1:0]        mag_s1;
	logic [RndW-1:0]        rnd;
	logic [ResW-1:0]        res_s2;
	logic signed [SineW-1:0] sine_s3;

	// output queue
	logic [1:0]              cnt_q;
	logic signed [SineW-1:0] head_q;
	logic signed [SineW-1:0] tail_q;

	assign adv              = cnt_q != QDepth;
	assign angle_chan.ready = adv;

	tsr_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid    (angle_chan.valid),
		.angle    (angle_chan.angle),
		.ctl_fwd  (ctl_c[0]),
		.term_fwd (term_c[0]),
		.x2_fwd   (x2_c[0]),
		.sum_fwd  (sum_c[0])
	);

	// one cell per Taylor term after the first
	for (genvar k = 1; k < TERMS; k++) begin : g_cell
		tsr_cell #(
			.K (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.ctl      (ctl_c[k-1]),
			.term     (term_c[k-1]),
			.x2       (x2_c[k-1]),
			.sum      (sum_c[k-1]),
			.ctl_fwd  (ctl_c[k]),
			.term_fwd (term_c[k]),
			.x2_fwd   (x2_c[k]),
			.sum_fwd  (sum_c[k])
		);
	end

	// round half up at the output lsb, then clamp to one
	assign rnd = (RndW'(mag_s1) + Half) >> Sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			// a sum that dipped below zero is taken by magnitude with the sign turned
			ctl_s1 <= '{valid: ctl_c[TERMS-1].valid,
				neg: ctl_c[TERMS-1].neg ^ sum_c[TERMS-1][SumW-1]};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= sum_c[TERMS-1][SumW-1] ? $unsigned(-sum_c[TERMS-1])
				: $unsigned(sum_c[TERMS-1]);
			res_s2  <= (rnd > One) ? ResW'(One) : ResW'(rnd);
			// zero stays zero either way
			sine_s3 <= ctl_s2.neg ? -$signed(SineW'(res_s2)) : $signed(SineW'(res_s2));
		end
	end

	assign push = adv && ctl_s3.valid;
	assign pop  = sine_chan.valid && sine_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// head is the output register, tail the skid entry
	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			head_q <= sine_s3;
		end else if (cnt_q == QDepth && pop) begin
			head_q <= tail_q;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			tail_q <= sine_s3;
		end
	end

	assign sine_chan.valid = cnt_q != 2'd0;
	assign sine_chan.sine  = head_q;

endmodule
